[hdl/owse_pkg.sv]
// Shared constants for the one-wire master slot engine: command codes, phase codes,
// configuration indexes, reset values and result beat bit positions.
// No dependencies.
`default_nettype none

package owse_pkg;

  localparam int BYTE_BITS = 8;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_R_HIGH    = 4'd1;
  localparam logic [3:0] PH_R_LOW     = 4'd2;
  localparam logic [3:0] PH_R_WAIT    = 4'd3;
  localparam logic [3:0] PH_R_WIN     = 4'd4;
  localparam logic [3:0] PH_W_LOW     = 4'd5;
  localparam logic [3:0] PH_W_BIT     = 4'd6;
  localparam logic [3:0] PH_RD_LEAD   = 4'd7;
  localparam logic [3:0] PH_RD_LOW    = 4'd8;
  localparam logic [3:0] PH_RD_SAMPLE = 4'd9;
  localparam logic [3:0] PH_RD_REC    = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_START     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_BIT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_START     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_SAMPLE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_RECOVERY  = 3'd7;

  localparam logic [9:0] RST_RESET_LOW    = 10'd750;
  localparam logic [7:0] RST_PRES_TIMEOUT = 8'd60;
  localparam logic [9:0] RST_PRES_WINDOW  = 10'd480;
  localparam logic [7:0] RST_WR_START     = 8'd10;
  localparam logic [7:0] RST_WR_BIT       = 8'd50;
  localparam logic [7:0] RST_RD_START     = 8'd1;
  localparam logic [7:0] RST_RD_SAMPLE    = 8'd5;
  localparam logic [7:0] RST_RD_RECOVERY  = 8'd55;

  localparam int R_HIGH_TICKS  = 5;
  localparam int RD_LEAD_TICKS = 2;

  localparam int OUT_DEN_BIT  = 0;
  localparam int OUT_LVL_BIT  = 1;
  localparam int OUT_BUSY_BIT = 2;
  localparam int OUT_DONE_BIT = 3;
  localparam int OUT_FAIL_BIT = 4;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [7:0] pres_timeout;
    logic [9:0] pres_window;
    logic [7:0] wr_start;
    logic [7:0] wr_bit;
    logic [7:0] rd_start;
    logic [7:0] rd_sample;
    logic [7:0] rd_recovery;
  } owse_cfg_t;

endpackage

`default_nettype wire

[hdl/one_wire_master_slot_engine.sv]
// One-wire bus master slot engine: input register, single-pass phase sequencer, result
// register and configuration registers. Depends on owse_pkg.
//
// Usage: one beat on the s_axis channel per clock cycle at most. Each beat carries a tick
// flag (one microsecond passed), a command in tuser, a write byte and the sampled line
// level. While idle, a command beat starts a bus reset, a byte write or a byte read; commands
// given while busy are ignored. Every input beat yields exactly one result beat on m_axis
// with the pin drive enable, pin level, busy, done pulse, presence failure flag and the
// last byte read. Phases of zero length are crossed within the same beat.
// Result path: the input register captures an input beat, then the result register takes it
// from the input register. Throughput: one beat per cycle while m_axis_tready keeps the result
// register drained; the sequencer state updates in the cycle the input register hands
// its beat to the result register.
// Stall: while the result register holds an untaken beat, one further input beat is held
// in the input register, then s_axis_tready drops.
// Reset: all timing registers return to their defaults, the sequencer is idle, the pin is
// driven high, no beats are held. Configuration writes are taken on any cycle with
// cfg_we_i high and must only be issued while no command is in progress.
`default_nettype none

module one_wire_master_slot_engine
  import owse_pkg::*;
#(
  parameter int TICK_COUNT_WIDTH = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // [0] tick, [8:1] wr_byte, [9] line_in, [15:10] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]             s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] pin_drive_enable, [1] pin_level, [2] busy_res, [3] done_res,
  // [4] presence_fail, [12:5] rd_byte, [15:13] zero
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int TW = TICK_COUNT_WIDTH;
  localparam int CW = (TW > 10) ? TW : 10;

  typedef struct packed {
    logic [3:0]           phase;
    logic [TW-1:0]        slot;
    logic [2:0]           bit_idx;
    logic [BYTE_BITS-1:0] shift;
    logic [7:0]           pwait;
    logic                 den;
    logic                 dlv;
    logic                 fail;
    logic [BYTE_BITS-1:0] last;
    logic [9:0]           win;
  } eng_t;

  typedef struct packed {
    eng_t st;
    logic tk;
    logic done;
    logic stop;
  } work_t;

  localparam eng_t ENG_RESET = '{
    phase: PH_IDLE, slot: '0, bit_idx: '0, shift: '0, pwait: '0,
    den: 1'b1, dlv: 1'b1, fail: 1'b0, last: '0, win: '0
  };

  function automatic eng_t enter(eng_t s, logic [3:0] ph, logic en, logic lv);
    eng_t r;
    r       = s;
    r.phase = ph;
    r.slot  = '0;
    r.den   = en;
    r.dlv   = lv;
    return r;
  endfunction

  function automatic logic [CW-1:0] dur_of(logic [3:0] ph, owse_cfg_t c, logic [9:0] win);
    logic [CW-1:0] d;
    case (ph)
      PH_R_HIGH:    d = CW'(R_HIGH_TICKS);
      PH_R_LOW:     d = CW'(c.reset_low);
      PH_R_WIN:     d = CW'(win);
      PH_W_LOW:     d = CW'(c.wr_start);
      PH_W_BIT:     d = CW'(c.wr_bit);
      PH_RD_LEAD:   d = CW'(RD_LEAD_TICKS);
      PH_RD_LOW:    d = CW'(c.rd_start);
      PH_RD_SAMPLE: d = CW'(c.rd_sample);
      PH_RD_REC:    d = CW'(c.rd_recovery);
      default:      d = '0;
    endcase
    return d;
  endfunction

  function automatic work_t step(work_t w, owse_cfg_t c, logic line);
    work_t         r;
    logic [TW-1:0] cnt;
    logic          last_bit;
    r        = w;
    cnt      = w.st.slot;
    last_bit = (w.st.bit_idx == 3'(BYTE_BITS - 1));
    if (!w.stop && w.st.phase != PH_IDLE) begin
      if (w.st.phase == PH_R_WAIT) begin
        if (!line) begin
          r.st.win = (c.pres_window > {2'b00, w.st.pwait}) ?
                     c.pres_window - {2'b00, w.st.pwait} : '0;
          r.st     = enter(r.st, PH_R_WIN, 1'b1, 1'b1);
          r.tk     = 1'b0;
        end else begin
          r.stop = 1'b1;
          if (w.tk) begin
            r.tk = 1'b0;
            if (w.st.pwait >= c.pres_timeout) begin
              r.st.fail = 1'b1;
              r.done    = 1'b1;
              r.st      = enter(r.st, PH_IDLE, 1'b0, 1'b1);
            end else begin
              r.st.pwait = w.st.pwait + 8'd1;
            end
          end
        end
      end else begin
        if (w.tk) begin
          r.tk = 1'b0;
          if (cnt != '1) begin
            cnt = cnt + TW'(1);
          end
        end
        r.st.slot = cnt;
        if (CW'(cnt) < dur_of(w.st.phase, c, w.st.win)) begin
          r.stop = 1'b1;
        end else begin
          case (w.st.phase)
            PH_R_HIGH: r.st = enter(r.st, PH_R_LOW, 1'b1, 1'b0);
            PH_R_LOW:  r.st = enter(r.st, PH_R_WAIT, 1'b0, 1'b1);
            PH_R_WIN: begin
              r.st.fail = 1'b0;
              r.done    = 1'b1;
              r.st      = enter(r.st, PH_IDLE, 1'b1, 1'b1);
            end
            PH_W_LOW: r.st = enter(r.st, PH_W_BIT, 1'b1, w.st.shift[0]);
            PH_W_BIT: begin
              r.st.shift = w.st.shift >> 1;
              if (last_bit) begin
                r.st.bit_idx = '0;
                r.done       = 1'b1;
                r.st         = enter(r.st, PH_IDLE, 1'b1, 1'b1);
              end else begin
                r.st.bit_idx = w.st.bit_idx + 3'd1;
                r.st         = enter(r.st, PH_W_LOW, 1'b1, 1'b0);
              end
            end
            PH_RD_LEAD: r.st = enter(r.st, PH_RD_LOW, 1'b1, 1'b0);
            PH_RD_LOW:  r.st = enter(r.st, PH_RD_SAMPLE, 1'b0, 1'b1);
            PH_RD_SAMPLE: begin
              r.st.shift = {line, w.st.shift[BYTE_BITS-1:1]};
              r.st       = enter(r.st, PH_RD_REC, 1'b0, 1'b1);
            end
            PH_RD_REC: begin
              if (last_bit) begin
                r.st.bit_idx = '0;
                r.done       = 1'b1;
                r.st.last    = w.st.shift;
                r.st         = enter(r.st, PH_IDLE, 1'b1, 1'b1);
              end else begin
                r.st.bit_idx = w.st.bit_idx + 3'd1;
                r.st         = enter(r.st, PH_RD_LOW, 1'b1, 1'b0);
              end
            end
            default: r.st = enter(r.st, PH_IDLE, 1'b1, 1'b1);
          endcase
        end
      end
    end
    return r;
  endfunction

  owse_cfg_t cfg_q;

  logic                 in_vld_q;
  logic                 in_tick_q;
  logic [1:0]           in_act_q;
  logic [BYTE_BITS-1:0] in_wr_q;
  logic                 in_line_q;

  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [OUT_TDATA_W-1:0] out_data_d;

  eng_t  state_q;
  eng_t  state_d;
  work_t w0, w1, w2, w3, w4, wf;
  logic  adv;
  logic  wr_loop_zero;
  logic  rd_loop_zero;
  logic  in_wr_loop;
  logic  in_rd_loop;
  logic [3:0] rd_left;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        reset_low: RST_RESET_LOW, pres_timeout: RST_PRES_TIMEOUT,
        pres_window: RST_PRES_WINDOW, wr_start: RST_WR_START, wr_bit: RST_WR_BIT,
        rd_start: RST_RD_START, rd_sample: RST_RD_SAMPLE, rd_recovery: RST_RD_RECOVERY
      };
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESET_LOW:    cfg_q.reset_low    <= cfg_data_i;
        CFG_PRES_TIMEOUT: cfg_q.pres_timeout <= cfg_data_i[7:0];
        CFG_PRES_WINDOW:  cfg_q.pres_window  <= cfg_data_i;
        CFG_WR_START:     cfg_q.wr_start     <= cfg_data_i[7:0];
        CFG_WR_BIT:       cfg_q.wr_bit       <= cfg_data_i[7:0];
        CFG_RD_START:     cfg_q.rd_start     <= cfg_data_i[7:0];
        CFG_RD_SAMPLE:    cfg_q.rd_sample    <= cfg_data_i[7:0];
        CFG_RD_RECOVERY:  cfg_q.rd_recovery  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w0.st   = state_q;
    w0.tk   = in_tick_q;
    w0.done = 1'b0;
    w0.stop = 1'b0;
    if (state_q.phase == PH_IDLE) begin
      w0.tk = 1'b0;
      case (in_act_q)
        ACT_RESET: begin
          w0.st.pwait = '0;
          w0.st       = enter(w0.st, PH_R_HIGH, 1'b1, 1'b1);
        end
        ACT_WRITE: begin
          w0.st.shift   = in_wr_q;
          w0.st.bit_idx = '0;
          w0.st         = enter(w0.st, PH_W_LOW, 1'b1, 1'b0);
        end
        ACT_READ: begin
          w0.st.shift   = '0;
          w0.st.bit_idx = '0;
          w0.st         = enter(w0.st, PH_RD_LEAD, 1'b1, 1'b1);
        end
        default: ;
      endcase
    end
  end

  assign w1 = step(w0, cfg_q, in_line_q);
  assign w2 = step(w1, cfg_q, in_line_q);
  assign w3 = step(w2, cfg_q, in_line_q);
  assign w4 = step(w3, cfg_q, in_line_q);

  // Slot loops whose phases are all zero length run to the end of the byte in this beat.
  assign wr_loop_zero = (cfg_q.wr_start == '0) && (cfg_q.wr_bit == '0);
  assign rd_loop_zero = (cfg_q.rd_start == '0) && (cfg_q.rd_sample == '0) &&
                        (cfg_q.rd_recovery == '0);
  assign in_wr_loop   = (w4.st.phase == PH_W_LOW) || (w4.st.phase == PH_W_BIT);
  assign in_rd_loop   = (w4.st.phase == PH_RD_LOW) || (w4.st.phase == PH_RD_SAMPLE) ||
                        (w4.st.phase == PH_RD_REC);
  assign rd_left      = (w4.st.phase == PH_RD_REC) ?
                        4'(BYTE_BITS - 1) - {1'b0, w4.st.bit_idx} :
                        4'(BYTE_BITS) - {1'b0, w4.st.bit_idx};

  always_comb begin
    wf = w4;
    if (!w4.stop && in_wr_loop && wr_loop_zero) begin
      wf.st.bit_idx = '0;
      wf.done       = 1'b1;
      wf.st         = enter(wf.st, PH_IDLE, 1'b1, 1'b1);
    end else if (!w4.stop && in_rd_loop && rd_loop_zero) begin
      wf.st.shift   = (w4.st.shift >> rd_left) |
                      (in_line_q ? ~({BYTE_BITS{1'b1}} >> rd_left) : '0);
      wf.st.last    = wf.st.shift;
      wf.st.bit_idx = '0;
      wf.done       = 1'b1;
      wf.st         = enter(wf.st, PH_IDLE, 1'b1, 1'b1);
    end
  end

  assign state_d    = wf.st;
  assign out_data_d = {3'b000, wf.st.last, wf.st.fail, wf.done,
                       (wf.st.phase != PH_IDLE), wf.st.dlv, wf.st.den};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= ENG_RESET;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tick_q <= s_axis_tdata[0];
      in_wr_q   <= s_axis_tdata[BYTE_BITS:1];
      in_line_q <= s_axis_tdata[BYTE_BITS+1];
      in_act_q  <= s_axis_tuser;
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[hdl/owse_chk.sv]
// Port-level checks for the one-wire master slot engine, bound to the top level.
// Depends on owse_pkg and one_wire_master_slot_engine.
`default_nettype none

module owse_chk
  import owse_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[OUT_DONE_BIT] && m_axis_tdata[OUT_BUSY_BIT]))
    else $error("done beat still reports busy");

  a_done_level_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[OUT_DONE_BIT]) |-> m_axis_tdata[OUT_LVL_BIT])
    else $error("command finished with pin level low");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result beat pending");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind one_wire_master_slot_engine owse_chk u_owse_chk (.*);

`default_nettype wire

[sim/tb.sv]
// Self-checking bench for the one-wire master slot engine: drives command and tick beats,
// predicts each status beat in step with the bus sequencer or takes it from a directed table, and checks each one.
// Depends on owse_pkg and one_wire_master_slot_engine.
module tb;
  import owse_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [7:0] rd;
    logic       fail;
    logic       done;
    logic       busy;
    logic       lvl;
    logic       den;
  } status_t;

  typedef struct packed {
    logic       tick;
    logic [1:0] act;
    logic [7:0] wr;
    logic       line;
    logic       typed;
    status_t    want;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [0] tick, [8:1] wr_byte, [9] line_in, [15:10] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] action
  logic [1:0]             s_axis_tuser = ACT_NONE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] pin_drive_enable, [1] pin_level, [2] busy_res, [3] done_res,
  // [4] presence_fail, [12:5] rd_byte, [15:13] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  one_wire_master_slot_engine i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Sequencer shadow
  owse_cfg_t   timing;
  logic [3:0]  ph;
  logic [9:0]  ph_ticks;
  int          bit_no;
  logic [7:0]  shreg;
  logic [7:0]  pres_cnt;
  logic        den, lvl, fail;
  logic [7:0]  last_rd;
  logic [9:0]  win_len;

  status_t     pending_status[$];
  int          err_cnt = 0;
  int          work_beats = 0;
  int          status_checked = 0;
  int          settings_used = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_spent = 1'b0;

  function automatic void reset_sequencer();
    timing = '{RST_RESET_LOW, RST_PRES_TIMEOUT, RST_PRES_WINDOW, RST_WR_START, RST_WR_BIT,
               RST_RD_START, RST_RD_SAMPLE, RST_RD_RECOVERY};
    ph = PH_IDLE;
    ph_ticks = '0;
    bit_no = 0;
    shreg = '0;
    pres_cnt = '0;
    den = 1'b1;
    lvl = 1'b1;
    fail = 1'b0;
    last_rd = '0;
    win_len = '0;
  endfunction

  function automatic void enter_phase(logic [3:0] p, logic en, logic lv);
    ph = p;
    ph_ticks = '0;
    den = en;
    lvl = lv;
  endfunction

  function automatic logic [9:0] phase_len(logic [3:0] p);
    case (p)
      PH_R_HIGH:    return 10'(R_HIGH_TICKS);
      PH_R_LOW:     return timing.reset_low;
      PH_R_WIN:     return win_len;
      PH_W_LOW:     return 10'(timing.wr_start);
      PH_W_BIT:     return 10'(timing.wr_bit);
      PH_RD_LEAD:   return 10'(RD_LEAD_TICKS);
      PH_RD_LOW:    return 10'(timing.rd_start);
      PH_RD_SAMPLE: return 10'(timing.rd_sample);
      PH_RD_REC:    return 10'(timing.rd_recovery);
      default:      return '0;
    endcase
  endfunction

  function automatic status_t advance_bus_master(logic tk, logic [1:0] act, logic [7:0] wr,
                                                 logic line);
    status_t s;
    logic    done;
    done = 1'b0;
    if (ph == PH_IDLE) begin
      tk = 1'b0;
      case (act)
        ACT_RESET: begin
          pres_cnt = '0;
          enter_phase(PH_R_HIGH, 1'b1, 1'b1);
        end
        ACT_WRITE: begin
          shreg = wr;
          bit_no = 0;
          enter_phase(PH_W_LOW, 1'b1, 1'b0);
        end
        ACT_READ: begin
          shreg = '0;
          bit_no = 0;
          enter_phase(PH_RD_LEAD, 1'b1, 1'b1);
        end
        default: ;
      endcase
    end
    for (int n = 0; n < 64 && ph != PH_IDLE; n++) begin
      if (ph == PH_R_WAIT) begin
        if (!line) begin
          win_len = (timing.pres_window > {2'b00, pres_cnt}) ?
                    timing.pres_window - {2'b00, pres_cnt} : '0;
          enter_phase(PH_R_WIN, 1'b1, 1'b1);
          tk = 1'b0;
        end else begin
          if (tk) begin
            tk = 1'b0;
            if (pres_cnt >= timing.pres_timeout) begin
              fail = 1'b1;
              done = 1'b1;
              enter_phase(PH_IDLE, 1'b0, 1'b1);
            end else begin
              pres_cnt = pres_cnt + 8'd1;
            end
          end
          break;
        end
      end else begin
        if (tk) begin
          tk = 1'b0;
          if (ph_ticks != '1) ph_ticks = ph_ticks + 10'd1;
        end
        if (ph_ticks < phase_len(ph)) break;
        case (ph)
          PH_R_HIGH: enter_phase(PH_R_LOW, 1'b1, 1'b0);
          PH_R_LOW:  enter_phase(PH_R_WAIT, 1'b0, 1'b1);
          PH_R_WIN: begin
            fail = 1'b0;
            done = 1'b1;
            enter_phase(PH_IDLE, 1'b1, 1'b1);
          end
          PH_W_LOW:  enter_phase(PH_W_BIT, 1'b1, shreg[0]);
          PH_W_BIT: begin
            shreg = shreg >> 1;
            if (bit_no >= BYTE_BITS - 1) begin
              bit_no = 0;
              done = 1'b1;
              enter_phase(PH_IDLE, 1'b1, 1'b1);
            end else begin
              bit_no++;
              enter_phase(PH_W_LOW, 1'b1, 1'b0);
            end
          end
          PH_RD_LEAD: enter_phase(PH_RD_LOW, 1'b1, 1'b0);
          PH_RD_LOW:  enter_phase(PH_RD_SAMPLE, 1'b0, 1'b1);
          PH_RD_SAMPLE: begin
            shreg = {line, shreg[7:1]};
            enter_phase(PH_RD_REC, 1'b0, 1'b1);
          end
          PH_RD_REC: begin
            if (bit_no >= BYTE_BITS - 1) begin
              bit_no = 0;
              done = 1'b1;
              last_rd = shreg;
              enter_phase(PH_IDLE, 1'b1, 1'b1);
            end else begin
              bit_no++;
              enter_phase(PH_RD_LOW, 1'b1, 1'b0);
            end
          end
          default: enter_phase(PH_IDLE, 1'b1, 1'b1);
        endcase
      end
    end
    s.den  = den;
    s.lvl  = lvl;
    s.busy = (ph != PH_IDLE);
    s.done = done;
    s.fail = fail;
    s.rd   = last_rd;
    return s;
  endfunction

  // Hold the line high in reset phases until the chosen presence count (random when noisy)
  function automatic logic bus_level(int pres_after, bit noisy);
    if (!noisy && ph inside {PH_R_HIGH, PH_R_LOW, PH_R_WAIT})
      return int'(pres_cnt) < pres_after;
    return 1'($urandom_range(1));
  endfunction

  function automatic owse_cfg_t random_timing();
    owse_cfg_t c;
    c.reset_low    = 10'($urandom_range(0, 12));
    c.pres_timeout = 8'($urandom_range(0, 10));
    c.pres_window  = 10'($urandom_range(0, 16));
    c.wr_start     = 8'($urandom_range(0, 5));
    c.wr_bit       = 8'($urandom_range(0, 5));
    c.rd_start     = 8'($urandom_range(0, 5));
    c.rd_sample    = 8'($urandom_range(0, 5));
    c.rd_recovery  = 8'($urandom_range(0, 5));
    return c;
  endfunction

  task automatic load_timing(input owse_cfg_t c);
    logic [CFG_DATA_W-1:0] val [8];
    val[CFG_RESET_LOW]    = c.reset_low;
    val[CFG_PRES_TIMEOUT] = 10'(c.pres_timeout);
    val[CFG_PRES_WINDOW]  = c.pres_window;
    val[CFG_WR_START]     = 10'(c.wr_start);
    val[CFG_WR_BIT]       = 10'(c.wr_bit);
    val[CFG_RD_START]     = 10'(c.rd_start);
    val[CFG_RD_SAMPLE]    = 10'(c.rd_sample);
    val[CFG_RD_RECOVERY]  = 10'(c.rd_recovery);
    for (int k = 0; k < 8; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(k);
      cfg_data_i <= val[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    timing = c;
    settings_used++;
  endtask

  task automatic send_beat(input logic tk, input logic [1:0] act, input logic [7:0] wr,
                           input logic line, input logic typed, input status_t want);
    status_t predicted;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, line, wr, tk};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    if (ph != PH_IDLE || act != ACT_NONE) work_beats++;
    predicted = advance_bus_master(tk, act, wr, line);
    pending_status.push_back(typed ? want : predicted);
  endtask

  task automatic run_command(input logic [1:0] act, input int pres_after);
    bit noisy;
    noisy = ($urandom_range(9) == 0);
    send_beat(1'($urandom_range(1)), act, 8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
    while (ph != PH_IDLE)
      send_beat($urandom_range(99) < 85,
                ($urandom_range(9) == 0) ? 2'($urandom) : ACT_NONE,
                8'($urandom), bus_level(pres_after, noisy), 1'b0, '0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : status_check
    status_t want;
    status_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = status_t'(m_axis_tdata[12:0]);
      if (pending_status.size() == 0) begin
        $error("status beat %h with nothing pending", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_status.pop_front();
        check_field("pin_drive_enable", want.den, got.den);
        check_field("pin_level", want.lvl, got.lvl);
        check_field("busy_res", want.busy, got.busy);
        check_field("done_res", want.done, got.done);
        check_field("presence_fail", want.fail, got.fail);
        check_field("rd_byte", want.rd, got.rd);
        status_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_spent) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_spent <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t  dir_tab [25];
    int    goal;
    // want: rd, fail, done, busy, lvl, den
    dir_tab = '{
      '{1'b0, ACT_NONE,  8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{1'b1, ACT_NONE,  8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{1'b1, ACT_RESET, 8'h00, 1'b1, 1'b0, '0},
      '{1'b1, ACT_READ,  8'hFF, 1'b1, 1'b0, '0},
      '{1'b1, ACT_WRITE, 8'h00, 1'b1, 1'b0, '0},
      '{1'b1, ACT_RESET, 8'h55, 1'b1, 1'b0, '0},
      '{1'b0, ACT_NONE,  8'hAA, 1'b1, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b1, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b1, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{1'b0, ACT_RESET, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b0, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b0, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b0, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b0, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'hFF, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{1'b0, ACT_WRITE, 8'hA5, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{1'b1, ACT_WRITE, 8'h5A, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{1'b0, ACT_READ,  8'h00, 1'b1, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b1, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b1, 1'b1, {8'hFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{1'b0, ACT_READ,  8'hFF, 1'b0, 1'b0, '0},
      '{1'b1, ACT_RESET, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, ACT_NONE,  8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{1'b0, ACT_NONE,  8'h00, 1'b1, 1'b0, '0}
    };
    reset_sequencer();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero-length configured phases: write and read bit slots collapse into single beats
    load_timing('0);
    foreach (dir_tab[r])
      send_beat(dir_tab[r].tick, dir_tab[r].act, dir_tab[r].wr, dir_tab[r].line,
                dir_tab[r].typed, dir_tab[r].want);

    for (int p = 0; p < 8; p++) begin
      settle();
      load_timing(random_timing());
      gap_pct   = (p % 4 == 1) ? 80 : (p % 4 == 3) ? 17 : 0;
      stall_pct = (p % 4 == 2) ? 80 : (p % 4 == 3) ? 17 : 0;
      if (p == 4) hold_req <= 1'b1;
      goal = work_beats + 120;
      while (work_beats < goal) begin
        case ($urandom_range(9))
          0:       send_beat(1'($urandom_range(1)), ACT_NONE, 8'($urandom),
                             1'($urandom_range(1)), 1'b0, '0);
          1, 2, 3: run_command(ACT_RESET, ($urandom_range(3) == 0) ? 512 :
                                          $urandom_range(0, int'(timing.pres_timeout)));
          4, 5, 6: run_command(ACT_WRITE, 0);
          default: run_command(ACT_READ, 0);
        endcase
      end
    end

    // Long presence wait under the widest timeout: the window saturates at zero
    settle();
    gap_pct = 0;
    stall_pct = 0;
    load_timing('{10'd1, 8'hFF, 10'd100, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    run_command(ACT_RESET, 200);
    run_command(ACT_WRITE, 0);
    run_command(ACT_READ, 0);

    settle();
    repeat (10) @(posedge clk_i);
    $display("Bus reset, write and read slots over %0d timing settings, idle and stall mixes",
             settings_used);
    $display("%0d working beats driven, %0d status beats checked, %0d mismatches",
             work_beats, status_checked, err_cnt);
    if (err_cnt == 0 && pending_status.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
